/* design/iida_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the indexed insert/delete array
package iida_pkg;

   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_INSERT = 3'd1;
   localparam logic [2:0] ACT_READ   = 3'd2;
   localparam logic [2:0] ACT_DELETE = 3'd3;
   localparam logic [2:0] ACT_WRITE  = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_UP,
      CELL_DOWN
   } cell_op_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [5:0]         index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [6:0]         entry_count;
   } rsp_type;

endpackage

/* design/indexed_insert_delete_array_unit.sv */
`timescale 1ns / 1ps
// indexed insert/delete array: row of entry cells with count and response register
//
// A dense ordered array of signed 32-bit entries plus an entry count.
// A request (action, index, value) is taken when start is high and busy is low;
// busy stays low, so a request may be issued in every cycle.
// Actions: append, insert at index, read, delete at index, overwrite at index.
// Insert and delete move every affected entry in the same cycle: each cell
// takes its neighbor's entry under a broadcast shift command.
// The response (status, read_value, entry_count) appears on rsp_data in the
// cycle after the request, marked by rsp_valid for exactly one cycle; the
// receiver cannot hold it off. Throughput 1 item per cycle, as the cell row
// and the count register are updated directly by each accepted request.
// A full array answers append and insert with the full status; an index at
// or beyond the count answers with the index status and changes nothing.
// Reset clears the count and the response strobe; entry contents are left
// as they are and only entries below the count are ever read.
module indexed_insert_delete_array_unit #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iida_pkg::req_type req_data,
   output logic              rsp_valid,
   output iida_pkg::rsp_type rsp_data
);
   import iida_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int KW = (CW > 7) ? CW : 7;
   localparam int XW = (IW > 6) ? IW : 6;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               fire;
   logic               full;
   logic               idx_ok;
   logic [KW-1:0]      idx_k;
   logic [KW-1:0]      cnt_k;
   logic [XW-1:0]      idx_x;
   logic [IW-1:0]      rd_sel;
   cell_op_type        cell_op;
   logic [CW-1:0]      cell_pos;
   logic signed [31:0] cell_q [CAPACITY];

   assign busy   = 1'b0;
   assign fire   = start & ~busy;
   assign full   = (count_ff == FULL_COUNT);
   assign idx_k  = KW'(req_data.index);
   assign idx_ok = idx_k < KW'(count_ff);
   assign idx_x  = XW'(req_data.index);
   assign rd_sel = idx_x[IW-1:0];

   always_comb begin
      cell_op  = CELL_HOLD;
      cell_pos = idx_k[CW-1:0];
      count_in = count_ff;
      rsp_in.status     = ST_DONE;
      rsp_in.read_value = '0;
      unique case (req_data.action)
         ACT_APPEND: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               cell_op  = CELL_LOAD;
               cell_pos = count_ff;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_INSERT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else if (!idx_ok) begin
               rsp_in.status = ST_INDEX;
            end else begin
               cell_op  = CELL_UP;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_READ: begin
            if (idx_ok) rsp_in.read_value = cell_q[rd_sel];
            else rsp_in.status = ST_INDEX;
         end
         ACT_DELETE: begin
            if (idx_ok) begin
               cell_op  = CELL_DOWN;
               count_in = count_ff - 1'b1;
            end else begin
               rsp_in.status = ST_INDEX;
            end
         end
         ACT_WRITE: begin
            if (idx_ok) cell_op = CELL_LOAD;
            else rsp_in.status = ST_INDEX;
         end
         default: begin
            cell_op = CELL_HOLD;
         end
      endcase
      if (!fire) begin
         cell_op  = CELL_HOLD;
         count_in = count_ff;
      end
      cnt_k = KW'(count_in);
      rsp_in.entry_count = cnt_k[6:0];
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] prev_q;
      logic signed [31:0] next_q;
      if (i == 0) begin : g_first
         assign prev_q = '0;
      end else begin : g_prev
         assign prev_q = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_q = '0;
      end else begin : g_next
         assign next_q = cell_q[i+1];
      end
      iida_cell #(
         .CNT_W     (CW),
         .CELL_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .op       (cell_op),
         .pos      (cell_pos),
         .limit    (count_ff),
         .value    (req_data.value),
         .prev_data(prev_q),
         .next_data(next_q),
         .data     (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("missing response after accepted item");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !fire |=> !rsp_valid)
      else $error("response without accepted item");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      fire && full && (req_data.action == ACT_APPEND || req_data.action == ACT_INSERT)
      |=> rsp_data.status == ST_FULL && $stable(count_ff))
      else $error("full array changed on append or insert");

endmodule

/* design/iida_cell.sv */
`timescale 1ns / 1ps
// one storage cell of the array: holds, loads, or takes a neighbor's entry
module iida_cell #(
   parameter int CNT_W      = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  iida_pkg::cell_op_type op,
   input  logic [CNT_W-1:0]      pos,
   input  logic [CNT_W-1:0]      limit,
   input  logic signed [31:0]    value,
   input  logic signed [31:0]    prev_data,
   input  logic signed [31:0]    next_data,
   output logic signed [31:0]    data
);
   import iida_pkg::*;

   localparam logic [CNT_W:0] MY_POS = (CNT_W+1)'(CELL_INDEX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;
   logic [CNT_W:0]     pos_x;
   logic [CNT_W:0]     limit_x;

   assign pos_x   = {1'b0, pos};
   assign limit_x = {1'b0, limit};

   always_comb begin
      data_in = data_ff;
      unique case (op)
         CELL_LOAD: begin
            if (MY_POS == pos_x) data_in = value;
         end
         CELL_UP: begin
            // new item lands at pos, cells above it up to the old end take from below
            if (MY_POS == pos_x) data_in = value;
            else if (MY_POS > pos_x && MY_POS <= limit_x) data_in = prev_data;
         end
         CELL_DOWN: begin
            if (MY_POS >= pos_x && (MY_POS + 1'b1) < limit_x) data_in = next_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* dv/iida_array_checker.sv */
`timescale 1ns / 1ps
// response checker for the indexed insert/delete array: predicts every response and compares
module iida_array_checker #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  iida_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  iida_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding,
   output int                fill_level,
   output int                answered,
   output int                full_seen,
   output int                index_errs
);
   import iida_pkg::*;

   logic signed [31:0] shadow_cells [CAPACITY];
   int                 shadow_count;
   rsp_type            predicted_rsp_q [$];

   initial begin
      fail_count   = 0;
      answered     = 0;
      full_seen    = 0;
      index_errs   = 0;
      shadow_count = 0;
      outstanding  = 0;
      fill_level   = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   // updates the shadow array and returns the response the block must give
   function automatic rsp_type apply_array_op(input req_type r);
      rsp_type ans;
      int      j;
      ans.status     = ST_DONE;
      ans.read_value = '0;
      case (r.action)
         ACT_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               shadow_cells[shadow_count] = r.value;
               shadow_count++;
            end
         end
         ACT_INSERT: begin
            // full check wins over the index check
            if (shadow_count >= CAPACITY) begin
               ans.status = ST_FULL;
            end else if (int'(r.index) >= shadow_count) begin
               ans.status = ST_INDEX;
            end else begin
               for (j = shadow_count; j > int'(r.index); j--)
                  shadow_cells[j] = shadow_cells[j - 1];
               shadow_cells[r.index] = r.value;
               shadow_count++;
            end
         end
         ACT_READ: begin
            if (int'(r.index) >= shadow_count)
               ans.status = ST_INDEX;
            else
               ans.read_value = shadow_cells[r.index];
         end
         ACT_DELETE: begin
            if (int'(r.index) >= shadow_count) begin
               ans.status = ST_INDEX;
            end else begin
               for (j = int'(r.index); j + 1 < shadow_count; j++)
                  shadow_cells[j] = shadow_cells[j + 1];
               shadow_count--;
            end
         end
         ACT_WRITE: begin
            if (int'(r.index) >= shadow_count)
               ans.status = ST_INDEX;
            else
               shadow_cells[r.index] = r.value;
         end
         default: begin
            // spare action codes leave everything alone
         end
      endcase
      ans.entry_count = 7'(shadow_count);
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         predicted_rsp_q.delete();
         shadow_count = 0;
      end else begin
         // push before pop so a same-edge response still pairs with the oldest item
         if (start && !busy)
            predicted_rsp_q.push_back(apply_array_op(req_data));
         if (rsp_valid) begin
            if (predicted_rsp_q.size() == 0) begin
               report_mismatch("response with no item waiting");
            end else begin
               want = predicted_rsp_q.pop_front();
               answered = answered + 1;
               if (want.status == ST_FULL)
                  full_seen = full_seen + 1;
               if (want.status == ST_INDEX)
                  index_errs = index_errs + 1;
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value got %h want %h",
                                            rsp_data.read_value, want.read_value));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_data.entry_count, want.entry_count));
            end
         end
      end
      outstanding <= predicted_rsp_q.size();
      fill_level  <= shadow_count;
   end

endmodule

/* dv/indexed_insert_delete_array_unit_test.sv */
`timescale 1ns / 1ps
// testbench top for the indexed insert/delete array: stimulus, watchdog and verdict
module indexed_insert_delete_array_unit_test;
   import iida_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 1925;
   localparam int CALM_TAIL    = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   typedef enum int {
      MODE_GROW,
      MODE_SHRINK,
      MODE_MIXED
   } traffic_mode_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int fill_level;
   int answered;
   int full_seen;
   int index_errs;
   int idle_cycles = 0;

   indexed_insert_delete_array_unit #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   iida_array_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .outstanding(outstanding),
      .fill_level (fill_level),
      .answered   (answered),
      .full_seen  (full_seen),
      .index_errs (index_errs)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", idle_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // holds the item until the block takes it, then maybe leaves a gap
   task automatic issue(input logic [2:0] act, input logic [5:0] idx,
                        input logic [31:0] val, input bit allow_gap);
      start           <= 1'b1;
      req_data.action <= act;
      req_data.index  <= idx;
      req_data.value  <= val;
      do @(posedge clock); while (busy);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   initial begin
      traffic_mode_type mode;
      int               phase_left;
      int               roll;
      int               n;
      bit               quiet;
      logic [2:0]       act;
      logic [5:0]       idx;
      logic [31:0]      val;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty array: every indexed action is out of range, then three appends
      issue(ACT_READ,   6'd0, 32'h0000_0000, 1);
      issue(ACT_DELETE, 6'd0, 32'h0000_0000, 1);
      issue(ACT_INSERT, 6'd0, 32'h1234_5678, 1);
      issue(ACT_WRITE,  6'd0, 32'h1234_5678, 1);
      issue(ACT_APPEND, 6'd63, 32'h7FFF_FFFF, 1);
      issue(ACT_APPEND, 6'd0, 32'h8000_0000, 1);
      issue(ACT_APPEND, 6'd0, 32'h0000_0000, 1);
      // insert at the front, then in the middle
      issue(ACT_INSERT, 6'd0, 32'hFFFF_FFFF, 1);
      issue(ACT_INSERT, 6'd2, 32'h5555_5555, 1);
      for (int k = 0; k < 5; k++)
         issue(ACT_READ, 6'(k), 32'hFFFF_FFFF, 1);
      issue(ACT_WRITE,  6'd4, 32'hAAAA_AAAA, 1);
      issue(ACT_READ,   6'd4, 32'h0000_0000, 1);
      // insert cannot land at the end
      issue(ACT_INSERT, 6'd5, 32'h0BAD_0BAD, 1);
      issue(ACT_READ,   6'd63, 32'h0000_0000, 1);
      for (logic [3:0] a = {1'b0, ACT_SPARE_LO}; a <= {1'b0, ACT_SPARE_HI}; a++)
         issue(a[2:0], 6'd63, 32'hFFFF_FFFF, 1);
      // delete the last, the first, then a middle entry
      issue(ACT_DELETE, 6'd4, 32'h0000_0000, 1);
      issue(ACT_DELETE, 6'd0, 32'h0000_0000, 1);
      issue(ACT_READ,   6'd0, 32'h0000_0000, 1);
      issue(ACT_DELETE, 6'd1, 32'h0000_0000, 1);

      phase_left = 0;
      mode       = MODE_MIXED;
      quiet      = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            mode       = traffic_mode_type'($urandom_range(0, 2));
            phase_left = $urandom_range(30, 150);
            quiet      = ($urandom_range(0, 2) == 0);
         end
         phase_left--;

         roll = $urandom_range(0, 99);
         case (mode)
            MODE_GROW: begin
               if (roll < 45)      act = ACT_APPEND;
               else if (roll < 70) act = ACT_INSERT;
               else if (roll < 82) act = ACT_READ;
               else if (roll < 92) act = ACT_WRITE;
               else if (roll < 97) act = ACT_DELETE;
               else                act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            end
            MODE_SHRINK: begin
               if (roll < 50)      act = ACT_DELETE;
               else if (roll < 70) act = ACT_READ;
               else if (roll < 82) act = ACT_WRITE;
               else if (roll < 92) act = ACT_APPEND;
               else if (roll < 97) act = ACT_INSERT;
               else                act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            end
            default: begin
               if (roll < 97) act = 3'($urandom_range(ACT_APPEND, ACT_WRITE));
               else           act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            end
         endcase

         // mostly in-range indexes, fill level may lag by one item
         if (fill_level > 0 && $urandom_range(0, 99) < 85)
            idx = 6'($urandom_range(0, fill_level - 1));
         else
            idx = 6'($urandom_range(0, 63));

         roll = $urandom_range(0, 99);
         if (roll < 10)      val = 32'h7FFF_FFFF;
         else if (roll < 20) val = 32'h8000_0000;
         else if (roll < 30) val = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         else                val = $urandom();

         issue(act, idx, val, !quiet && (n < RANDOM_ITEMS - CALM_TAIL));
      end
      start <= 1'b0;

      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses, %0d index errors, %0d full rejections",
               answered, index_errs, full_seen);
      $display("mismatches: %0d", fail_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
design/iida_pkg.sv
design/iida_cell.sv
design/indexed_insert_delete_array_unit.sv
dv/iida_array_checker.sv
dv/indexed_insert_delete_array_unit_test.sv
